[design/icmp_probe_reply_parser_defines.svh]
// Assertion macros for the ICMP probe reply parser checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ICMP_PROBE_REPLY_PARSER_DEFINES_SVH
`define ICMP_PROBE_REPLY_PARSER_DEFINES_SVH

// Condition that must hold on the same edge as the antecedent
`define IPR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Condition that must hold on the edge after the antecedent
`define IPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/ipr_pkg.sv]
// Shared types and constants of the ICMP probe reply parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ipr_pkg;

    // Fixed protocol constants
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [7:0]  TYPE_UNREACHABLE = 8'd3;
    localparam logic [7:0]  CODE_PORT_UNREACH = 8'd3;
    localparam int          ICMP_HDR_BYTES   = 8;
    localparam int          HIGHEST_SEQUENCE = 10;
    localparam logic [15:0] BASE_PORT_RESET  = 16'd33434;

    // Configuration register indexes
    localparam logic CFG_PROBE_SRC_PORT = 1'b0;
    localparam logic CFG_BASE_DST_PORT  = 1'b1;

    // Verdict codes
    localparam logic [2:0] V_STORED       = 3'd0;
    localparam logic [2:0] V_OUT_OF_RANGE = 3'd1;
    localparam logic [2:0] V_NO_PROBE     = 3'd2;
    localparam logic [2:0] V_NOT_V4       = 3'd3;
    localparam logic [2:0] V_SHORT        = 3'd4;
    localparam logic [2:0] V_NOT_OURS     = 3'd5;
    localparam logic [2:0] V_OTHER_CODE   = 3'd6;
    localparam logic [2:0] V_OTHER_TYPE   = 3'd7;

    // Output stream widths
    localparam int TDATA_W = 112;
    localparam int TUSER_W = 4;

    // Fields captured from one packet
    typedef struct packed {
        logic [3:0]  version;
        logic [5:0]  hdr_out;     // outer header length in bytes
        logic [5:0]  hdr_in;      // quoted header length in bytes
        logic [31:0] addr_src;    // outer source address
        logic [31:0] addr_dst;    // quoted destination address
        logic [15:0] port_src;    // quoted UDP source port
        logic [15:0] port_dst;    // quoted UDP destination port
        logic [15:0] ip_id;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [7:0]  probe_ttl;   // TTL in quoted header
        logic [7:0]  reply_ttl;   // TTL of outer header
    } t_capture;

    // One verdict request
    typedef struct packed {
        logic [2:0]  verdict;
        logic        counts;
        logic [3:0]  seq;
        logic [31:0] responder;
        logic [31:0] queried;
        logic [15:0] ip_id;
        logic [7:0]  probe_ttl;
        logic [7:0]  reply_ttl;
        logic [7:0]  code;
    } t_result;

endpackage

[design/icmp_probe_reply_parser.sv]
// ICMP probe reply parser: one packet byte per cycle in, one verdict per packet out.
// A last byte's verdict passes from the input register to the output register.
// Throughput: one byte every cycle; an input register and an output register
// decouple the two sides, so a waiting verdict stalls only the next last byte.
// Reset: synchronous, active low; clears both registers' valid flags, the packet
// state and the configuration (probe source port 0, base destination port 33434).
`timescale 1ns / 1ps

module icmp_probe_reply_parser #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [15:0]                  i_cfg_wdata,
    // packet byte stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
    input  logic                         s_axis_tlast,  // last_byte
    // verdict stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [3:0] probe_sequence, [35:4] responder_address, [67:36] queried_address,
    // [83:68] reply_ip_id, [91:84] probe_arrival_ttl, [99:92] reply_ttl,
    // [107:100] unreachable_code, [111:108] zero
    output logic [ipr_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [2:0] verdict, [3] counts_as_reply
    output logic [ipr_pkg::TUSER_W-1:0]  m_axis_tuser
);
    import ipr_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic        r_in_valid;
    logic [15:0] r_probe_src, r_base_dst;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_out_free, w_adv;
    t_capture    w_cap;
    t_result     w_res;
    logic [POS_W-1:0] w_len;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_src <= '0;
            r_base_dst  <= BASE_PORT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PROBE_SRC_PORT: r_probe_src <= i_cfg_wdata;
                CFG_BASE_DST_PORT:  r_base_dst  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: a byte moves on unless it is a last byte facing a full output
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    ipr_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .POS_W            (POS_W)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_cap   (w_cap),
        .o_len   (w_len)
    );

    ipr_verdict #(
        .POS_W (POS_W)
    ) u_verdict (
        .i_cap        (w_cap),
        .i_len        (w_len),
        .i_probe_port (r_probe_src),
        .i_base_port  (r_base_dst),
        .o_res        (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) r_out <= w_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.code, r_out.reply_ttl, r_out.probe_ttl,
                            r_out.ip_id, r_out.queried, r_out.responder, r_out.seq};
    assign m_axis_tuser  = {r_out.counts, r_out.verdict};

endmodule

[design/ipr_capture.sv]
// Byte position counter and field capture registers of the reply parser.
// Depends on ipr_pkg.
`timescale 1ns / 1ps

module ipr_capture #(
    parameter int MAX_PACKET_BYTES = 512,
    parameter int POS_W            = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output ipr_pkg::t_capture  o_cap,
    output logic [POS_W-1:0]   o_len
);
    import ipr_pkg::*;

    // wide enough for any header offset and any position
    localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    t_capture         r_cap, n_cap;

    // Place the current byte into every field whose position it hits
    always_comb begin
        logic             take;
        logic [CMP_W-1:0] p, h, u, d_a0, d_a1, d_pt;
        logic [5:0]       hdr_out, hdr_in;
        n_cap = r_cap;
        take  = (r_pos < POS_MAX);
        p     = CMP_W'(r_pos);
        hdr_out = (take && r_pos == '0) ? {i_byte[3:0], 2'b00} : r_cap.hdr_out;
        h       = CMP_W'(hdr_out);
        hdr_in  = (take && p == h + CMP_W'(ICMP_HDR_BYTES)) ? {i_byte[3:0], 2'b00}
                                                            : r_cap.hdr_in;
        u    = h + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(hdr_in);
        d_a0 = p - CMP_W'(12);
        d_a1 = p - (h + CMP_W'(24));
        d_pt = p - u;
        n_pos = take ? r_pos + 1'b1 : r_pos;

        if (take) begin
            n_cap.hdr_out = hdr_out;
            n_cap.hdr_in  = hdr_in;
            if (r_pos == '0) n_cap.version = i_byte[7:4];
            if (p == CMP_W'(4)) n_cap.ip_id[15:8] = i_byte;
            if (p == CMP_W'(5)) n_cap.ip_id[7:0]  = i_byte;
            if (p == CMP_W'(8)) n_cap.reply_ttl   = i_byte;
            // outer source address, bytes 12..15
            if (d_a0 < CMP_W'(4)) begin
                case (d_a0[1:0])
                    2'd0:    n_cap.addr_src[31:24] = i_byte;
                    2'd1:    n_cap.addr_src[23:16] = i_byte;
                    2'd2:    n_cap.addr_src[15:8]  = i_byte;
                    default: n_cap.addr_src[7:0]   = i_byte;
                endcase
            end
            if (p == h)                n_cap.msg_type  = i_byte;
            if (p == h + CMP_W'(1))    n_cap.msg_code  = i_byte;
            if (p == h + CMP_W'(16))   n_cap.probe_ttl = i_byte;
            // quoted destination address
            if (d_a1 < CMP_W'(4)) begin
                case (d_a1[1:0])
                    2'd0:    n_cap.addr_dst[31:24] = i_byte;
                    2'd1:    n_cap.addr_dst[23:16] = i_byte;
                    2'd2:    n_cap.addr_dst[15:8]  = i_byte;
                    default: n_cap.addr_dst[7:0]   = i_byte;
                endcase
            end
            // quoted UDP ports
            if (d_pt < CMP_W'(4)) begin
                case (d_pt[1:0])
                    2'd0:    n_cap.port_src[15:8] = i_byte;
                    2'd1:    n_cap.port_src[7:0]  = i_byte;
                    2'd2:    n_cap.port_dst[15:8] = i_byte;
                    default: n_cap.port_dst[7:0]  = i_byte;
                endcase
            end
        end
    end

    assign o_cap = n_cap;
    assign o_len = n_pos;

    // State clears after the last byte of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cap <= '0;
        end else if (i_adv) begin
            if (i_last) begin
                r_pos <= '0;
                r_cap <= '0;
            end else begin
                r_pos <= n_pos;
                r_cap <= n_cap;
            end
        end
    end

endmodule

[design/ipr_verdict.sv]
// Verdict and report field logic of the reply parser, purely combinational.
// Depends on ipr_pkg.
`timescale 1ns / 1ps

module ipr_verdict #(
    parameter int POS_W = 10
) (
    input  ipr_pkg::t_capture i_cap,
    input  logic [POS_W-1:0]  i_len,
    input  logic [15:0]       i_probe_port,
    input  logic [15:0]       i_base_port,
    output ipr_pkg::t_result  o_res
);
    import ipr_pkg::*;

    localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

    always_comb begin
        logic [CMP_W-1:0] len, h, u, need;
        logic [15:0]      seq_diff;
        logic             in_range, report;
        logic [2:0]       verdict;
        len = CMP_W'(i_len);
        h   = CMP_W'(i_cap.hdr_out);
        u   = h + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(i_cap.hdr_in);
        // last byte needed by a type 3 report
        need = u + CMP_W'(3);
        if (h + CMP_W'(27) > need) need = h + CMP_W'(27);
        if (CMP_W'(15) > need) need = CMP_W'(15);
        seq_diff = i_cap.port_dst - i_base_port;
        in_range = (i_cap.port_dst >= i_base_port) &&
                   (seq_diff <= 16'(HIGHEST_SEQUENCE));
        report = 1'b0;

        // checks in priority order
        if (i_probe_port == '0) begin
            verdict = V_NO_PROBE;
        end else if (i_cap.version != IP_VERSION_4) begin
            verdict = V_NOT_V4;
        end else if (len < h || len <= u + CMP_W'(1)) begin
            verdict = V_SHORT;
        end else if (i_cap.port_src != i_probe_port) begin
            verdict = V_NOT_OURS;
        end else if (i_cap.msg_type != TYPE_UNREACHABLE) begin
            verdict = V_OTHER_TYPE;
        end else if (len <= need) begin
            verdict = V_SHORT;
        end else begin
            report = 1'b1;
            if (i_cap.msg_code != CODE_PORT_UNREACH) verdict = V_OTHER_CODE;
            else if (in_range)                       verdict = V_STORED;
            else                                     verdict = V_OUT_OF_RANGE;
        end

        o_res           = '0;
        o_res.verdict   = verdict;
        o_res.counts    = (verdict == V_STORED) || (verdict == V_OUT_OF_RANGE);
        o_res.seq       = (verdict == V_STORED) ? seq_diff[3:0] : 4'd0;
        if (report) begin
            o_res.responder = i_cap.addr_src;
            o_res.queried   = i_cap.addr_dst;
            o_res.ip_id     = i_cap.ip_id;
            o_res.probe_ttl = i_cap.probe_ttl;
            o_res.reply_ttl = i_cap.reply_ttl;
            o_res.code      = i_cap.msg_code;
        end
    end

endmodule

[design/ipr_checker.sv]
// Port-level checker for the ICMP probe reply parser, bound to the top level.
// Depends on ipr_pkg and icmp_probe_reply_parser_defines.svh.
`timescale 1ns / 1ps
`include "icmp_probe_reply_parser_defines.svh"

module ipr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ipr_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic [ipr_pkg::TUSER_W-1:0]  m_axis_tuser
);
    import ipr_pkg::*;

    logic [2:0] w_verdict;
    logic       w_counts, w_reports;

    assign w_verdict = m_axis_tuser[2:0];
    assign w_counts  = (w_verdict == V_STORED) || (w_verdict == V_OUT_OF_RANGE);
    assign w_reports = w_counts || (w_verdict == V_OTHER_CODE);

    // reply flag agrees with the verdict
    `IPR_ASSERT_IMPLY(a_counts_flag, m_axis_tvalid, m_axis_tuser[3] == w_counts, "reply flag mismatch")

    // a sequence is given only for a stored reply
    `IPR_ASSERT_IMPLY(a_seq_only_stored, m_axis_tvalid && (w_verdict != V_STORED), m_axis_tdata[3:0] == 4'd0, "sequence on unstored reply")

    // report fields and padding are zero when nothing is reported
    `IPR_ASSERT_IMPLY(a_fields_zero, m_axis_tvalid && !w_reports, m_axis_tdata[111:4] == '0, "report fields not cleared")

    // a stalled verdict holds
    `IPR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled verdict changed")

endmodule

bind icmp_probe_reply_parser ipr_checker u_ipr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_icmp_probe_reply_parser.sv]
// Self-checking testbench for icmp_probe_reply_parser: streams packets byte by byte,
// predicts each verdict in a local parser model and compares every output field.
// Depends on ipr_pkg and the icmp_probe_reply_parser RTL only.
`timescale 1ns / 1ps

module tb_icmp_probe_reply_parser;

    import ipr_pkg::*;

    localparam int PACKET_LIMIT = 512;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 6;

    typedef logic [7:0] t_octet;

    // Shape of one generated reply packet
    typedef struct {
        logic [3:0]  version;
        logic [3:0]  ihl_out;
        logic [3:0]  ihl_in;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ip_id;
        logic [31:0] responder;
        logic [31:0] queried;
        logic [7:0]  reply_ttl;
        logic [7:0]  probe_ttl;
        int          len;
    } t_reply_desc;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [15:0]         i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [7:0] data_byte
    logic                s_axis_tlast = 1'b0; // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [3:0] seq, [35:4] responder, [67:36] queried, [83:68] ip id,
    // [91:84] probe ttl, [99:92] reply ttl, [107:100] code
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [TUSER_W-1:0]  m_axis_tuser;       // [2:0] verdict, [3] counts_as_reply

    icmp_probe_reply_parser #(
        .MAX_PACKET_BYTES(PACKET_LIMIT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Verdicts predicted but not yet seen on the output
    t_result verdicts_due[$];

    int    error_count   = 0;
    int    bytes_sent    = 0;
    int    packets_sent  = 0;
    int    cycle_count   = 0;
    int    verdict_seen[8];
    bit    src_idle_on   = 1'b1;
    bit    sink_idle_on  = 1'b1;
    int    hold_request  = 0;
    int    stall_left    = 0;

    // Local copy of the configuration registers
    logic [15:0] cfg_probe_port;
    logic [15:0] cfg_base_port;

    // Parser state of the packet in flight
    int          pk_pos;
    int          pk_hdr_out;
    int          pk_hdr_in;
    logic [3:0]  pk_version;
    logic [31:0] pk_responder;
    logic [31:0] pk_queried;
    logic [15:0] pk_sport;
    logic [15:0] pk_dport;
    logic [15:0] pk_id;
    logic [7:0]  pk_type;
    logic [7:0]  pk_code;
    logic [7:0]  pk_probe_ttl;
    logic [7:0]  pk_reply_ttl;

    function automatic void clear_packet();
        pk_pos       = 0;
        pk_hdr_out   = 0;
        pk_hdr_in    = 0;
        pk_version   = '0;
        pk_responder = '0;
        pk_queried   = '0;
        pk_sport     = '0;
        pk_dport     = '0;
        pk_id        = '0;
        pk_type      = '0;
        pk_code      = '0;
        pk_probe_ttl = '0;
        pk_reply_ttl = '0;
    endfunction

    // Capture one byte at position p; header lengths move the field offsets
    function automatic void take_octet(input int p, input t_octet b);
        int h;
        int u;
        if (p == 0) begin
            pk_version = b[7:4];
            pk_hdr_out = 4 * b[3:0];
        end
        h = pk_hdr_out;
        if (p == h + ICMP_HDR_BYTES)
            pk_hdr_in = 4 * b[3:0];
        u = h + ICMP_HDR_BYTES + pk_hdr_in;
        if (p == 4 || p == 5) pk_id[8*(5-p) +: 8] = b;
        if (p == 8) pk_reply_ttl = b;
        if (p >= 12 && p <= 15) pk_responder[8*(15-p) +: 8] = b;
        if (p == h) pk_type = b;
        if (p == h + 1) pk_code = b;
        if (p == h + 16) pk_probe_ttl = b;
        if (p >= h + 24 && p <= h + 27) pk_queried[8*(h+27-p) +: 8] = b;
        if (p == u || p == u + 1) pk_sport[8*(u+1-p) +: 8] = b;
        if (p == u + 2 || p == u + 3) pk_dport[8*(u+3-p) +: 8] = b;
    endfunction

    // Advance the parser by one byte; returns 1 with the verdict on a last byte
    function automatic bit predict_octet(input t_octet b, input bit last, output t_result r);
        int         len;
        int         h;
        int         u;
        int         need;
        int         seq;
        logic [2:0] v;
        bit         report;
        r      = '0;
        report = 1'b0;
        seq    = 0;
        if (pk_pos < PACKET_LIMIT) begin
            take_octet(pk_pos, b);
            pk_pos++;
        end
        if (!last) return 1'b0;

        len = pk_pos;
        h   = pk_hdr_out;
        u   = h + ICMP_HDR_BYTES + pk_hdr_in;
        if (cfg_probe_port == 16'd0) begin
            v = V_NO_PROBE;
        end else if (pk_version != IP_VERSION_4) begin
            v = V_NOT_V4;
        end else if (len < h || len <= u + 1) begin
            v = V_SHORT;
        end else if (pk_sport != cfg_probe_port) begin
            v = V_NOT_OURS;
        end else if (pk_type != TYPE_UNREACHABLE) begin
            v = V_OTHER_TYPE;
        end else begin
            // every reported field must have arrived
            need = u + 3;
            if (h + 27 > need) need = h + 27;
            if (need < 15) need = 15;
            if (len <= need) begin
                v = V_SHORT;
            end else begin
                report = 1'b1;
                if (pk_code != CODE_PORT_UNREACH) begin
                    v = V_OTHER_CODE;
                end else if (pk_dport >= cfg_base_port &&
                             int'(pk_dport) - int'(cfg_base_port) <= HIGHEST_SEQUENCE) begin
                    v   = V_STORED;
                    seq = int'(pk_dport) - int'(cfg_base_port);
                end else begin
                    v = V_OUT_OF_RANGE;
                end
            end
        end

        r.verdict = v;
        r.counts  = (v == V_STORED || v == V_OUT_OF_RANGE);
        r.seq     = seq[3:0];
        if (report) begin
            r.responder = pk_responder;
            r.queried   = pk_queried;
            r.ip_id     = pk_id;
            r.probe_ttl = pk_probe_ttl;
            r.reply_ttl = pk_reply_ttl;
            r.code      = pk_code;
        end
        clear_packet();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Output side: check each accepted verdict, then choose next cycle's ready
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict request with nothing pending: tuser 0x%0h", m_axis_tuser);
                    error_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    verdict_seen[want.verdict]++;
                    check_field("verdict", 32'(want.verdict), 32'(m_axis_tuser[2:0]));
                    check_field("counts_as_reply", 32'(want.counts), 32'(m_axis_tuser[3]));
                    check_field("probe_sequence", 32'(want.seq), 32'(m_axis_tdata[3:0]));
                    check_field("responder_address", want.responder, m_axis_tdata[35:4]);
                    check_field("queried_address", want.queried, m_axis_tdata[67:36]);
                    check_field("reply_ip_id", 32'(want.ip_id), 32'(m_axis_tdata[83:68]));
                    check_field("probe_arrival_ttl", 32'(want.probe_ttl),
                                32'(m_axis_tdata[91:84]));
                    check_field("reply_ttl", 32'(want.reply_ttl), 32'(m_axis_tdata[99:92]));
                    check_field("unreachable_code", 32'(want.code),
                                32'(m_axis_tdata[107:100]));
                end
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                   verdicts_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one byte and wait until the parser takes it
    task automatic offer_octet(input t_octet b, input bit last);
        t_result r;
        if (src_idle_on && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_octet(b, last, r))
            verdicts_due.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_packet(input t_octet pkt[]);
        foreach (pkt[i])
            offer_octet(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // Stop sending and let every pending verdict come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_PROBE_SRC_PORT) cfg_probe_port = value;
        else cfg_base_port = value;
    endtask

    function automatic int full_length(input logic [3:0] ihl_out, input logic [3:0] ihl_in);
        int h;
        int n;
        h = 4 * ihl_out;
        n = h + ICMP_HDR_BYTES + 4 * ihl_in + 4;
        if (h + 28 > n) n = h + 28;
        if (n < 16) n = 16;
        return n;
    endfunction

    // Well-formed port-unreachable reply to probe number seq, random content
    function automatic t_reply_desc base_reply(input int seq);
        t_reply_desc d;
        d.version   = IP_VERSION_4;
        d.ihl_out   = 4'd5;
        d.ihl_in    = 4'd5;
        d.msg_type  = TYPE_UNREACHABLE;
        d.msg_code  = CODE_PORT_UNREACH;
        d.sport     = cfg_probe_port;
        d.dport     = cfg_base_port + 16'(seq);
        d.ip_id     = 16'($urandom);
        d.responder = $urandom;
        d.queried   = $urandom;
        d.reply_ttl = 8'($urandom);
        d.probe_ttl = 8'($urandom);
        d.len       = full_length(d.ihl_out, d.ihl_in) + $urandom_range(0, 4);
        return d;
    endfunction

    function automatic void build_reply(input t_reply_desc d, output t_octet pkt[]);
        int h;
        int u;
        int n;
        h = 4 * d.ihl_out;
        u = h + ICMP_HDR_BYTES + 4 * d.ihl_in;
        n = full_length(d.ihl_out, d.ihl_in);
        if (d.len > n) n = d.len;
        pkt = new[n];
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        pkt[0] = {d.version, d.ihl_out};
        pkt[4] = d.ip_id[15:8];
        pkt[5] = d.ip_id[7:0];
        pkt[8] = d.reply_ttl;
        for (int k = 0; k < 4; k++) pkt[12+k] = d.responder[8*(3-k) +: 8];
        pkt[h]     = d.msg_type;
        pkt[h + 1] = d.msg_code;
        pkt[h + 8] = {IP_VERSION_4, d.ihl_in};
        pkt[h + 16] = d.probe_ttl;
        for (int k = 0; k < 4; k++) pkt[h+24+k] = d.queried[8*(3-k) +: 8];
        pkt[u]     = d.sport[15:8];
        pkt[u + 1] = d.sport[7:0];
        pkt[u + 2] = d.dport[15:8];
        pkt[u + 3] = d.dport[7:0];
        pkt = new[d.len](pkt);
    endfunction

    task automatic send_reply(input t_reply_desc d);
        t_octet pkt[];
        build_reply(d, pkt);
        send_packet(pkt);
    endtask

    task automatic send_fill(input int len, input t_octet value);
        t_octet pkt[];
        pkt = new[len];
        foreach (pkt[i]) pkt[i] = value;
        send_packet(pkt);
    endtask

    // Random bytes, sometimes with a plausible first byte
    task automatic send_noise();
        t_octet pkt[];
        pkt = new[$urandom_range(1, 70)];
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        if ($urandom_range(0, 1) == 0) pkt[0] = {IP_VERSION_4, 4'd5};
        send_packet(pkt);
    endtask

    function automatic logic [3:0] random_ihl();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return 4'($urandom_range(0, 4));
        if (pick < 5) return 4'($urandom_range(6, 15));
        return 4'd5;
    endfunction

    // Mostly well-formed replies with a few broken fields
    function automatic t_reply_desc random_reply();
        t_reply_desc d;
        int full;
        d = base_reply($urandom_range(0, 12));
        if ($urandom_range(0, 15) == 0) d.version = 4'($urandom);
        d.ihl_out = random_ihl();
        d.ihl_in  = random_ihl();
        if ($urandom_range(0, 6) == 0) d.msg_type = 8'($urandom);
        if ($urandom_range(0, 4) == 0) d.msg_code = 8'($urandom);
        if ($urandom_range(0, 5) == 0) d.sport = 16'($urandom);
        if ($urandom_range(0, 7) == 0) d.dport = 16'($urandom);
        full  = full_length(d.ihl_out, d.ihl_in);
        d.len = full + $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) d.len = $urandom_range(1, full);
        if ($urandom_range(0, 99) == 0) d.len = $urandom_range(PACKET_LIMIT + 1, 640);
        return d;
    endfunction

    // Reset values: no probe sent yet, then default base port
    task automatic test_reset_values();
        send_reply(base_reply(0));
        write_register(CFG_PROBE_SRC_PORT, 16'h8123);
        send_reply(base_reply(3));
        wait_drained();
    endtask

    // One packet per verdict but no-probe, and per length boundary
    task automatic test_directed_cases();
        t_reply_desc d;
        d = base_reply(0);
        d.responder = '0; d.queried = '0; d.ip_id = '0; d.reply_ttl = '0; d.probe_ttl = '0;
        send_reply(d);
        d = base_reply(HIGHEST_SEQUENCE);
        d.responder = '1; d.queried = '1; d.ip_id = '1; d.reply_ttl = '1; d.probe_ttl = '1;
        send_reply(d);
        send_reply(base_reply(HIGHEST_SEQUENCE + 1));
        send_reply(base_reply(-1));
        d = base_reply(2);  d.msg_code = 8'd0;  send_reply(d);
        d = base_reply(2);  d.msg_type = 8'd11; send_reply(d);
        d = base_reply(2);  d.sport = cfg_probe_port ^ 16'h0001; send_reply(d);
        d = base_reply(2);  d.version = 4'd6; send_reply(d);
        // length boundaries for 20-byte headers: sport done at 50, all fields at 52
        d = base_reply(1);  d.len = 12; send_reply(d);
        d = base_reply(1);  d.len = 49; send_reply(d);
        d = base_reply(1);  d.len = 51; send_reply(d);
        d = base_reply(1);  d.len = 52; send_reply(d);
        d = base_reply(1);  d.len = 50; d.msg_type = 8'd0; send_reply(d);
        // header lengths at and below the legal range
        d = base_reply(4);  d.ihl_out = 4'd15; d.ihl_in = 4'd15;
        d.len = full_length(d.ihl_out, d.ihl_in); send_reply(d);
        d = base_reply(4);  d.ihl_out = 4'd0;  d.ihl_in = 4'd0;
        d.len = full_length(d.ihl_out, d.ihl_in); send_reply(d);
        d = base_reply(4);  d.ihl_out = 4'd2;  d.ihl_in = 4'd3;
        d.len = full_length(d.ihl_out, d.ihl_in) + 2; send_reply(d);
        // longer than the parser keeps
        d = base_reply(5);  d.len = PACKET_LIMIT + 8; send_reply(d);
        send_fill(40, 8'h00);
        send_fill(40, 8'hFF);
        send_fill(1, {IP_VERSION_4, 4'd5});
        wait_drained();
    endtask

    // Both registers at their extremes
    task automatic test_config_extremes();
        logic [15:0] bases[4]  = '{16'd0, 16'hFFFF, 16'hFFF8, BASE_PORT_RESET};
        logic [15:0] probes[4] = '{16'd1, 16'hFFFF, 16'h00FF, 16'h8123};
        foreach (bases[i]) begin
            write_register(CFG_BASE_DST_PORT, bases[i]);
            write_register(CFG_PROBE_SRC_PORT, probes[i]);
            send_reply(base_reply(0));
            send_reply(base_reply(HIGHEST_SEQUENCE + 1));
        end
        wait_drained();
    endtask

    // Output held off long enough that the input stalls
    task automatic test_backpressure();
        t_reply_desc d;
        hold_request = 200;
        src_idle_on  = 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0) begin
                send_reply(base_reply(i % 12));
            end else begin
                d = base_reply(0);
                d.len = $urandom_range(1, 3);
                send_reply(d);
            end
        end
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    // Random traffic phases, a new configuration after the first; the last runs flat out
    task automatic test_random_traffic();
        int phase_bytes;
        int phase_packets;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                write_register(CFG_PROBE_SRC_PORT,
                               ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
                write_register(CFG_BASE_DST_PORT, 16'($urandom));
            end
            if (phase == 3) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            phase_bytes   = bytes_sent;
            phase_packets = packets_sent;
            while (bytes_sent - phase_bytes < 60 || packets_sent - phase_packets < 1) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else send_reply(random_reply());
            end
            wait_drained();
        end
    endtask

    initial begin
        cfg_probe_port = 16'd0;
        cfg_base_port  = BASE_PORT_RESET;
        clear_packet();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_cases();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (verdicts_due.size() != 0) begin
            $error("%0d verdicts never arrived", verdicts_due.size());
            error_count++;
        end
        $display("Ran %0d packets (%0d bytes): edge cases, register extremes, stalls, random",
                 packets_sent, bytes_sent);
        $display("Verdicts checked by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4], verdict_seen[5], verdict_seen[6], verdict_seen[7]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
